// File: hw/rtl/fbd_pkg.sv
// Shared types, widths and constants for the fractional baud divider search.
package fbd_pkg;

   localparam int FRACTION_MAX  = 15;
   localparam int FRAC_W        = 4;
   localparam int CORE_W        = 28;
   localparam int BYTE_W        = 8;
   localparam int PCT_W         = 7;
   localparam int BAUD_W        = 24;
   localparam int ERR_W         = 17;
   localparam int CSR_IDX_W     = 2;
   localparam int DIV_W         = 36;
   localparam int DEN_W         = 32;
   localparam int DIV_STEPS     = DIV_W;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);
   localparam int DIVISOR_W     = 16;

   localparam logic [CORE_W-1:0] CORE_CLOCK_RESET   = CORE_W'(48000000);
   localparam logic [BYTE_W-1:0] AHB_DIV_RESET      = BYTE_W'(1);
   localparam logic [BYTE_W-1:0] UART_DIV_RESET     = BYTE_W'(1);
   localparam logic [PCT_W-1:0]  ERR_PCT_RESET      = PCT_W'(3);
   localparam logic [ERR_W-1:0]  NO_PAIR_ERROR      = ERR_W'(100000);
   localparam logic [DEN_W-1:0]  PERCENT_SCALE      = DEN_W'(100);
   localparam logic [DIV_W-1:0]  DIVISOR_MIN        = DIV_W'(3);
   localparam logic [DIV_W-1:0]  DIVISOR_MAX        = DIV_W'(65535);
   localparam int                UCLK_SHIFT         = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_CORE_CLOCK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AHB_DIV    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UART_DIV   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ERR_PCT    = 2'd3;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DEN_W-1:0] remainder;
   } div_rsp_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_CLK  = 6'b000010,
      ST_T    = 6'b000100,
      ST_D    = 6'b001000,
      ST_R    = 6'b010000,
      ST_LIM  = 6'b100000
   } state_type;

endpackage

// File: hw/rtl/fractional_baud_divider_search.sv
// Top level: fractional baud rate divider search around one shared divider.
//
// Usage: raise start with req_baud_rate while busy is low; that edge takes
// the beat and busy rises at once. The block derives the UART clock
// (core clock times AHB divider, over the UART divider, over 16), then walks
// multiplier 1..15 and add value 0..15, keeping the first pair with the
// smallest rate error and stopping on an exact match. When done it shows the
// result on the rsp_ ports for one cycle with rsp_valid high; busy drops in
// that same cycle, so a new start is already taken in the rsp_valid cycle.
// The receiver cannot stall: the result beat is gone after its one cycle.
// Sequencing: every division runs on the one shared divider. The clock setup
// takes one division and the final limit check one state of its own; each
// candidate takes two divisions, or three when its divisor lies in 3..65535.
// An exact match ends the search early; a zero baud rate skips the candidates.
// Configuration: csr_write_en with csr_index/csr_wdata writes a register in
// the same edge; write only while busy is low. Reset restores the register
// defaults (48 MHz, dividers 1, 3 percent) and idles the sequencer.
module fractional_baud_divider_search
   import fbd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [BAUD_W-1:0]    req_baud_rate,
   output logic                 rsp_valid,
   output logic [BYTE_W-1:0]    rsp_divisor_high,
   output logic [BYTE_W-1:0]    rsp_divisor_low,
   output logic [FRAC_W-1:0]    rsp_mul_value,
   output logic [FRAC_W-1:0]    rsp_div_add_value,
   output logic [ERR_W-1:0]     rsp_best_error,
   output logic                 rsp_accepted,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CORE_W-1:0]    csr_wdata
);

   logic [CORE_W-1:0] core_clk_ff;
   logic [BYTE_W-1:0] ahb_div_ff;
   logic [BYTE_W-1:0] uart_div_ff;
   logic [PCT_W-1:0]  err_pct_ff;

   state_type         state_ff, state_in;
   logic [BAUD_W-1:0] baud_ff, baud_in;
   logic [DEN_W-1:0]  uclk_ff, uclk_in;
   logic [DEN_W-1:0]  t_ff, t_in;
   logic [FRAC_W-1:0] mul_ff, mul_in;
   logic [FRAC_W-1:0] add_ff, add_in;
   logic [FRAC_W-1:0] best_mul_ff, best_mul_in;
   logic [FRAC_W-1:0] best_add_ff, best_add_in;
   logic [DIVISOR_W-1:0] best_div_ff, best_div_in;
   logic [ERR_W-1:0]  best_err_ff, best_err_in;
   logic              accepted_ff, accepted_in;
   logic              valid_ff, valid_in;
   logic              launch_ff, launch_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic              last_add, last_pair;
   logic [FRAC_W-1:0] nxt_mul, nxt_add;
   logic [DIV_W-1:0]  lim_num;
   logic [DIV_W-1:0]  lim_floor;
   logic [DIV_W-1:0]  d_round;
   logic              d_ok;
   logic [DEN_W-1:0]  rate;
   logic [DEN_W-1:0]  err;
   logic [DEN_W-1:0]  uclk_new;

   fbd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign div_req.start    = launch_ff;
   assign div_req.dividend = num_ff;
   assign div_req.divisor  = den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         core_clk_ff <= CORE_CLOCK_RESET;
         ahb_div_ff  <= AHB_DIV_RESET;
         uart_div_ff <= UART_DIV_RESET;
         err_pct_ff  <= ERR_PCT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CORE_CLOCK: core_clk_ff <= csr_wdata;
            CSR_AHB_DIV:    ahb_div_ff  <= csr_wdata[BYTE_W-1:0];
            CSR_UART_DIV:   uart_div_ff <= csr_wdata[BYTE_W-1:0];
            CSR_ERR_PCT:    err_pct_ff  <= csr_wdata[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      last_add  = (add_ff == FRAC_W'(FRACTION_MAX));
      last_pair = last_add && (mul_ff == FRAC_W'(FRACTION_MAX));
      nxt_mul   = last_add ? mul_ff + 1'b1 : mul_ff;
      nxt_add   = last_add ? '0 : add_ff + 1'b1;
      lim_num   = DIV_W'(baud_ff) * DIV_W'(err_pct_ff);
      // err < floor(lim_num / 100) holds exactly when lim_num >= 100 * (err + 1)
      lim_floor = (DIV_W'(best_err_ff) + DIV_W'(1)) * DIV_W'(PERCENT_SCALE);
      uclk_new  = div_rsp.quotient[DEN_W+UCLK_SHIFT-1:UCLK_SHIFT];
      d_round   = div_rsp.quotient
                + DIV_W'(div_rsp.remainder > DEN_W'(baud_ff >> 1));
      d_ok      = (d_round >= DIVISOR_MIN) && (d_round <= DIVISOR_MAX);
      rate      = div_rsp.quotient[DEN_W-1:0];
      err       = (rate <= DEN_W'(baud_ff)) ? DEN_W'(baud_ff) - rate
                                            : rate - DEN_W'(baud_ff);

      state_in    = state_ff;
      baud_in     = baud_ff;
      uclk_in     = uclk_ff;
      t_in        = t_ff;
      mul_in      = mul_ff;
      add_in      = add_ff;
      best_mul_in = best_mul_ff;
      best_add_in = best_add_ff;
      best_div_in = best_div_ff;
      best_err_in = best_err_ff;
      accepted_in = accepted_ff;
      valid_in    = 1'b0;
      launch_in   = 1'b0;
      num_in      = num_ff;
      den_in      = den_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               baud_in     = req_baud_rate;
               mul_in      = FRAC_W'(1);
               add_in      = '0;
               best_mul_in = FRAC_W'(1);
               best_add_in = '0;
               best_div_in = '0;
               best_err_in = NO_PAIR_ERROR;
               launch_in   = 1'b1;
               num_in      = DIV_W'(core_clk_ff) * DIV_W'(ahb_div_ff);
               den_in      = (uart_div_ff == '0) ? DEN_W'(1) : DEN_W'(uart_div_ff);
               state_in    = ST_CLK;
            end
         end
         ST_CLK: begin
            if (div_rsp.done) begin
               uclk_in = uclk_new;
               if (baud_ff == '0) begin
                  state_in = ST_LIM;
               end else begin
                  launch_in = 1'b1;
                  num_in    = DIV_W'(mul_ff) * DIV_W'(uclk_new);
                  den_in    = DEN_W'({1'b0, mul_ff} + {1'b0, add_ff});
                  state_in  = ST_T;
               end
            end
         end
         ST_T: begin
            if (div_rsp.done) begin
               t_in      = div_rsp.quotient[DEN_W-1:0];
               launch_in = 1'b1;
               num_in    = div_rsp.quotient;
               den_in    = DEN_W'(baud_ff);
               state_in  = ST_D;
            end
         end
         ST_D: begin
            if (div_rsp.done) begin
               if (d_ok) begin
                  launch_in = 1'b1;
                  num_in   = DIV_W'(t_ff);
                  den_in   = DEN_W'(d_round[DIVISOR_W-1:0]);
                  state_in = ST_R;
                  // hold candidate divisor in t until rate is known
                  t_in     = DEN_W'(d_round[DIVISOR_W-1:0]);
               end else if (last_pair) begin
                  state_in = ST_LIM;
               end else begin
                  launch_in = 1'b1;
                  mul_in   = nxt_mul;
                  add_in   = nxt_add;
                  num_in   = DIV_W'(nxt_mul) * DIV_W'(uclk_ff);
                  den_in   = DEN_W'({1'b0, nxt_mul} + {1'b0, nxt_add});
                  state_in = ST_T;
               end
            end
         end
         ST_R: begin
            if (div_rsp.done) begin
               if (err < DEN_W'(best_err_ff)) begin
                  best_mul_in = mul_ff;
                  best_add_in = add_ff;
                  best_div_in = t_ff[DIVISOR_W-1:0];
                  best_err_in = err[ERR_W-1:0];
               end
               if ((err == '0) || last_pair) begin
                  state_in = ST_LIM;
               end else begin
                  launch_in = 1'b1;
                  mul_in   = nxt_mul;
                  add_in   = nxt_add;
                  num_in   = DIV_W'(nxt_mul) * DIV_W'(uclk_ff);
                  den_in   = DEN_W'({1'b0, nxt_mul} + {1'b0, nxt_add});
                  state_in = ST_T;
               end
            end
         end
         ST_LIM: begin
            accepted_in = (lim_num >= lim_floor);
            valid_in    = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      baud_ff     <= baud_in;
      uclk_ff     <= uclk_in;
      t_ff        <= t_in;
      mul_ff      <= mul_in;
      add_ff      <= add_in;
      best_mul_ff <= best_mul_in;
      best_add_ff <= best_add_in;
      best_div_ff <= best_div_in;
      best_err_ff <= best_err_in;
      accepted_ff <= accepted_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= 1'b0;
         launch_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         launch_ff <= launch_in;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = valid_ff;
   assign rsp_divisor_high  = best_div_ff[DIVISOR_W-1:BYTE_W];
   assign rsp_divisor_low   = best_div_ff[BYTE_W-1:0];
   assign rsp_mul_value     = best_mul_ff;
   assign rsp_div_add_value = best_add_ff;
   assign rsp_best_error    = best_err_ff;
   assign rsp_accepted      = accepted_ff;

endmodule

// File: hw/rtl/fbd_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module fbd_div
   import fbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       shifted;
   logic [DEN_W+1:0]     diff;
   logic                 ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      ge      = !diff[DEN_W+1];
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule
